### sv/ckc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_pkg: shared types and constants of the C keyword / switch-case counter
// Keyword table, counter width, report word layout and helper functions.
// ----------------------------------------------------------------------------
package ckc_pkg;

	// counter width and reported field width
	localparam int COUNT_BITS = 16;
	localparam int FIELD_BITS = 16;

	// word buffer: up to eight letters, one byte each, length saturates at 15
	localparam int MAX_MATCH_LEN = 8;
	localparam int WORD_BITS     = 8 * MAX_MATCH_LEN;
	localparam int LEN_BITS      = 4;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	// keyword table
	localparam int KW_NUM       = 32;
	localparam int SWITCH_INDEX = 24;
	localparam int CASE_INDEX   = 2;

	// output queue depth (two words may enter per byte)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// report kinds
	localparam logic KIND_SWITCH = 1'b0;
	localparam logic KIND_TOTALS = 1'b1;

	// separator bytes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_GT      = 8'h3e;
	localparam logic [7:0] CH_LT      = 8'h3c;
	localparam logic [7:0] CH_LBRACE  = 8'h7b;
	localparam logic [7:0] CH_LPAREN  = 8'h28;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [LEN_BITS-1:0]   len_t;

	// keyword literals, right-justified (last letter in the low byte)
	localparam word_t KW_LIT [KW_NUM] = '{
		64'("auto"),     64'("break"),    64'("case"),     64'("char"),
		64'("const"),    64'("continue"), 64'("default"),  64'("do"),
		64'("double"),   64'("else"),     64'("enum"),     64'("float"),
		64'("for"),      64'("goto"),     64'("if"),       64'("int"),
		64'("long"),     64'("register"), 64'("return"),   64'("short"),
		64'("signed"),   64'("sizeof"),   64'("static"),   64'("struct"),
		64'("switch"),   64'("typedef"),  64'("union"),    64'("unsigned"),
		64'("void"),     64'("volatile"), 64'("while"),    64'("extern")
	};

	localparam len_t KW_LEN [KW_NUM] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
		4'd6, 4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 4'd2, 4'd3,
		4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5, 4'd6
	};

	// one report word
	typedef struct packed {
		logic                  kind;
		logic [FIELD_BITS-1:0] case_count;
		logic [FIELD_BITS-1:0] keyword_total;
		logic [FIELD_BITS-1:0] switch_total;
		logic                  last;
	} rpt_t;

	// matcher result
	typedef struct packed {
		logic hit;
		logic is_switch;
		logic is_case;
	} match_t;

	// reorder a right-justified literal so the first letter sits in the low byte
	function automatic word_t kw_pack(input word_t lit, input len_t len);
		word_t res;
		res = '0;
		for (int i = 0; i < MAX_MATCH_LEN; i++) begin
			if (i < int'(len))
				res[8*i +: 8] = lit[8*(int'(len) - 1 - i) +: 8];
		end
		return res;
	endfunction

	// saturating increment
	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : count_t'(v + 1'b1);
	endfunction

	// low field bits of a counter
	function automatic logic [FIELD_BITS-1:0] to_field(input count_t v);
		return FIELD_BITS'(v);
	endfunction

endpackage

### sv/c_keyword_switch_case_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_keyword_switch_case_counter_core: C keyword and switch/case counter
// Splits source text into words, counts keywords, switches and the case words
// of each switch, and reports per-switch case counts and end-of-text totals.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid/in_ready, char_code, end_of_text | in
//   out     | out_valid/out_ready, report_kind,         | out
//           | case_count, keyword_total, switch_total,  |
//           | last_of_run                               |
//
// One byte per cycle while the queue has room. A byte is held in the input
// register, then the word update, keyword compare and counters run in the same
// cycle and write 0, 1 or 2 words into a 4-entry output queue; a word is
// offered as soon as it is written into the queue. The queue drains one word
// per cycle, so sustained rate is set by out_ready; input stalls while the
// queue has fewer than two free slots.
// Reset clears all counters, the word buffer and the queue.
// ----------------------------------------------------------------------------
module c_keyword_switch_case_counter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      char_code,
	input  logic                            end_of_text,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            report_kind,
	output logic [ckc_pkg::FIELD_BITS-1:0]  case_count,
	output logic [ckc_pkg::FIELD_BITS-1:0]  keyword_total,
	output logic [ckc_pkg::FIELD_BITS-1:0]  switch_total,
	output logic                            last_of_run
);
	import ckc_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;

	// scan state
	word_t  letters_q;
	len_t   length_q;
	count_t kw_cnt_q;
	count_t sw_cnt_q;
	count_t cases_q;
	logic   sw_open_q;
	logic   after_sw_q;

	logic   room2;
	logic   advance;
	match_t match;

	logic   is_letter, is_sep;
	word_t  letters_d;
	len_t   length_d;
	count_t kw_cnt_d, sw_cnt_d, cases_d;
	logic   sw_open_d, after_sw_d;
	logic   rpt_sw, rpt_eot_sw, rpt_tot;
	rpt_t   rpt_a, rpt_b, rpt_c;
	rpt_t   push_d0, push_d1;
	logic [1:0] push_n;
	rpt_t   out_d;

	assign advance  = valid_s1 && room2;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	ckc_match u_match (
		.word_letters (letters_q),
		.word_length  (length_q),
		.match        (match)
	);

	// byte class
	always_comb begin
		is_letter = (char_s1 inside {[8'h41:8'h5a], [8'h61:8'h7a]});
		is_sep    = (char_s1 inside {CH_SPACE, CH_NEWLINE, CH_DOT, CH_GT,
			CH_LT, CH_LBRACE, CH_LPAREN});
	end

	// word, counter and switch state update
	always_comb begin
		letters_d  = letters_q;
		length_d   = length_q;
		kw_cnt_d   = kw_cnt_q;
		sw_cnt_d   = sw_cnt_q;
		cases_d    = cases_q;
		sw_open_d  = sw_open_q;
		after_sw_d = after_sw_q;
		rpt_sw     = 1'b0;
		if (is_letter) begin
			for (int i = 0; i < MAX_MATCH_LEN; i++) begin
				if (length_q == LEN_BITS'(i))
					letters_d[8*i +: 8] = char_s1;
			end
			if (length_q != LEN_MAX)
				length_d = len_t'(length_q + 1'b1);
		end else if (is_sep) begin
			if (match.hit)
				kw_cnt_d = sat_inc(kw_cnt_q);
			if (match.is_switch) begin
				sw_cnt_d   = sat_inc(sw_cnt_q);
				rpt_sw     = sw_open_q;
				sw_open_d  = 1'b1;
				after_sw_d = 1'b0;
				cases_d    = '0;
			end else if (sw_open_q) begin
				after_sw_d = 1'b1;
				if (match.is_case)
					cases_d = sat_inc(cases_q);
			end
			letters_d = '0;
			length_d  = '0;
		end
		rpt_eot_sw = eot_s1 && sw_open_d && after_sw_d;
		rpt_tot    = eot_s1;
	end

	// report words: the earlier switch report, the final switch report, totals
	always_comb begin
		rpt_a.kind          = KIND_SWITCH;
		rpt_a.case_count    = to_field(cases_q);
		rpt_a.keyword_total = to_field(kw_cnt_d);
		rpt_a.switch_total  = to_field(sw_cnt_d);
		rpt_a.last          = !eot_s1;

		rpt_b.kind          = KIND_SWITCH;
		rpt_b.case_count    = to_field(cases_d);
		rpt_b.keyword_total = to_field(kw_cnt_d);
		rpt_b.switch_total  = to_field(sw_cnt_d);
		rpt_b.last          = 1'b0;

		rpt_c.kind          = KIND_TOTALS;
		rpt_c.case_count    = '0;
		rpt_c.keyword_total = to_field(kw_cnt_d);
		rpt_c.switch_total  = to_field(sw_cnt_d);
		rpt_c.last          = 1'b1;

		push_d0 = rpt_sw ? rpt_a : (rpt_eot_sw ? rpt_b : rpt_c);
		push_d1 = rpt_c;
		push_n  = '0;
		if (advance)
			push_n = 2'(rpt_sw) + 2'(rpt_eot_sw) + 2'(rpt_tot);
	end

	// state registers; end of text returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letters_q  <= '0;
			length_q   <= '0;
			kw_cnt_q   <= '0;
			sw_cnt_q   <= '0;
			cases_q    <= '0;
			sw_open_q  <= 1'b0;
			after_sw_q <= 1'b0;
		end else if (advance) begin
			if (eot_s1) begin
				letters_q  <= '0;
				length_q   <= '0;
				kw_cnt_q   <= '0;
				sw_cnt_q   <= '0;
				cases_q    <= '0;
				sw_open_q  <= 1'b0;
				after_sw_q <= 1'b0;
			end else begin
				letters_q  <= letters_d;
				length_q   <= length_d;
				kw_cnt_q   <= kw_cnt_d;
				sw_cnt_q   <= sw_cnt_d;
				cases_q    <= cases_d;
				sw_open_q  <= sw_open_d;
				after_sw_q <= after_sw_d;
			end
		end
	end

	ckc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_d0   (push_d0),
		.push_d1   (push_d1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_d     (out_d)
	);

	assign report_kind   = out_d.kind;
	assign case_count    = out_d.case_count;
	assign keyword_total = out_d.keyword_total;
	assign switch_total  = out_d.switch_total;
	assign last_of_run   = out_d.last;

endmodule

### sv/ckc_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_match: keyword matcher
// Compares the buffered word against all 32 keywords in parallel.
// ----------------------------------------------------------------------------
module ckc_match (
	input  ckc_pkg::word_t  word_letters,
	input  ckc_pkg::len_t   word_length,
	output ckc_pkg::match_t match
);
	import ckc_pkg::*;

	logic [KW_NUM-1:0] eq;

	// one compare per keyword; longer words never match
	always_comb begin
		for (int k = 0; k < KW_NUM; k++) begin
			eq[k] = (word_length == KW_LEN[k]) &&
				(word_letters == kw_pack(KW_LIT[k], KW_LEN[k]));
		end
	end

	assign match.hit       = |eq;
	assign match.is_switch = eq[SWITCH_INDEX];
	assign match.is_case   = eq[CASE_INDEX];

endmodule

### sv/ckc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_queue: output report queue
// Small FIFO that takes up to two report words per cycle and gives one.
// ----------------------------------------------------------------------------
module ckc_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   push_n,
	input  ckc_pkg::rpt_t push_d0,
	input  ckc_pkg::rpt_t push_d1,
	output logic         room2,
	output logic         out_valid,
	input  logic         out_ready,
	output ckc_pkg::rpt_t out_d
);
	import ckc_pkg::*;

	rpt_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_d     = mem_q[rd_ptr_q];
	// room for a worst-case byte (two words), ignoring a pop in the same cycle
	assign room2     = (count_q <= QCNT_BITS'(QUEUE_DEPTH - 2));

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= push_d0;
		if (push_n == 2'd2)
			mem_q[QPTR_BITS'(wr_ptr_q + 1'b1)] <= push_d1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= QPTR_BITS'(wr_ptr_q + push_n);
			if (pop)
				rd_ptr_q <= QPTR_BITS'(rd_ptr_q + 1'b1);
			count_q <= QCNT_BITS'(count_q + QCNT_BITS'(push_n) - QCNT_BITS'(pop));
		end
	end

endmodule

### sv/ckc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_checker: port-level checks of the keyword counter
// Watches the output channel and the report words over time.
// ----------------------------------------------------------------------------
module ckc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           report_kind,
	input logic [ckc_pkg::FIELD_BITS-1:0] case_count,
	input logic                           last_of_run
);
	import ckc_pkg::*;

	// a stalled word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// totals always close the run of words of one byte
	a_tot_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_kind == KIND_TOTALS |-> last_of_run)
		else $error("totals word not last of run");

	// totals carry no case count
	a_tot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_kind == KIND_TOTALS |-> case_count == '0)
		else $error("totals word with nonzero case count");

	// the second word of a byte is queued together with the first
	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("second word of a run missing");

endmodule

bind c_keyword_switch_case_counter_core ckc_checker u_ckc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.report_kind (report_kind),
	.case_count  (case_count),
	.last_of_run (last_of_run)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of c_keyword_switch_case_counter_core
// Streams generated C-like source text into the counter one byte per input
// word. A scoreboard predicts each report word and checks it field by field.
// The stimulus is a few directed texts, then random token texts without
// idling, then random token texts with random stalls and a long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import ckc_pkg::*;

	localparam int QUIET_LIMIT = 5000;   // cycles without any handshake
	localparam int HOLD_CYCLES = 300;    // long receiver hold-off

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_byte_t;

	// DUT ports
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [7:0]            char_code   = 8'h00;
	logic                  end_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  report_kind;
	logic [FIELD_BITS-1:0] case_count;
	logic [FIELD_BITS-1:0] keyword_total;
	logic [FIELD_BITS-1:0] switch_total;
	logic                  last_of_run;

	// stimulus and scoreboard
	text_byte_t text_q[$];
	rpt_t       report_q[$];
	logic       gaps_on   = 1'b0;
	logic       hold_req  = 1'b0;
	logic       out_block = 1'b0;
	logic       in_fire   = 1'b0;
	int         err_cnt = 0, quiet = 0, queued = 0, texts_made = 0;
	int         n_bytes = 0, n_texts = 0, n_switch_rpt = 0, n_total_rpt = 0;

	// keyword list of the predictor
	string kw_name [32] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "float", "for", "goto", "if", "int",
		"long", "register", "return", "short", "signed", "sizeof", "static", "struct",
		"switch", "typedef", "union", "unsigned", "void", "volatile", "while", "extern"
	};

	// predicted counter state
	logic [WORD_BITS-1:0] p_letters  = '0;
	logic [3:0]           p_len      = '0;
	count_t               p_keywords = '0;
	count_t               p_switches = '0;
	count_t               p_cases    = '0;
	logic                 p_open     = 1'b0;
	logic                 p_followed = 1'b0;

	c_keyword_switch_case_counter_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.report_kind   (report_kind),
		.case_count    (case_count),
		.keyword_total (keyword_total),
		.switch_total  (switch_total),
		.last_of_run   (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// byte classes
	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return c inside {CH_SPACE, CH_NEWLINE, CH_DOT, CH_GT, CH_LT, CH_LBRACE, CH_LPAREN};
	endfunction

	function automatic count_t bump(input count_t v);
		return (&v) ? v : count_t'(v + 1);
	endfunction

	// index of the keyword held in the letter buffer, -1 if none
	function automatic int lookup_word(input logic [WORD_BITS-1:0] letters,
			input logic [3:0] len);
		int hit;
		hit = -1;
		if (len <= MAX_MATCH_LEN) begin
			for (int k = 0; k < 32; k++) begin
				if (hit < 0 && kw_name[k].len() == int'(len)) begin
					hit = k;
					for (int i = 0; i < kw_name[k].len(); i++)
						if (letters[8*i +: 8] != kw_name[k][i])
							hit = -1;
				end
			end
		end
		return hit;
	endfunction

	function automatic rpt_t make_report(input logic kind, input count_t cases);
		rpt_t r;
		r.kind          = kind;
		r.case_count    = FIELD_BITS'(cases);
		r.keyword_total = FIELD_BITS'(p_keywords);
		r.switch_total  = FIELD_BITS'(p_switches);
		r.last          = 1'b0;
		return r;
	endfunction

	// advance the predicted state by one byte, queue the reports it causes
	task automatic count_byte(input logic [7:0] c, input logic eot);
		rpt_t made [2];
		int   n;
		int   k;
		n = 0;
		if (is_letter(c)) begin
			if (p_len < MAX_MATCH_LEN)
				p_letters[8*p_len +: 8] = c;
			if (p_len != 4'hF)
				p_len++;
		end else if (is_sep(c)) begin
			k = lookup_word(p_letters, p_len);
			if (k >= 0)
				p_keywords = bump(p_keywords);
			if (k >= 0 && kw_name[k] == "switch") begin
				p_switches = bump(p_switches);
				// new switch closes the open one
				if (p_open) begin
					made[n] = make_report(KIND_SWITCH, p_cases);
					n++;
				end
				p_open     = 1'b1;
				p_followed = 1'b0;
				p_cases    = '0;
			end else if (p_open) begin
				p_followed = 1'b1;
				if (k >= 0 && kw_name[k] == "case")
					p_cases = bump(p_cases);
			end
			p_letters = '0;
			p_len     = '0;
		end
		// end of text: pending switch, totals, then back to the reset state
		if (eot) begin
			if (p_open && p_followed) begin
				made[n] = make_report(KIND_SWITCH, p_cases);
				n++;
			end
			made[n] = make_report(KIND_TOTALS, '0);
			n++;
			p_letters  = '0;
			p_len      = '0;
			p_keywords = '0;
			p_switches = '0;
			p_cases    = '0;
			p_open     = 1'b0;
			p_followed = 1'b0;
		end
		if (n > 0)
			made[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			report_q.push_back(made[i]);
	endtask

	task automatic note_mismatch(input string what);
		err_cnt++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	// text generation
	task automatic put(input logic [7:0] c, input logic eot);
		text_q.push_back('{c, eot});
		queued++;
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i], 1'b0);
	endtask

	function automatic string rand_letters(input int lo, input int hi);
		string      s;
		logic [7:0] c;
		int         n;
		s = "";
		n = $urandom_range(hi, lo);
		for (int i = 0; i < n; i++) begin
			c = 8'("a" + $urandom_range(25));
			if ($urandom_range(4) == 0)
				c = c ^ 8'h20;
			s = $sformatf("%s%c", s, c);
		end
		return s;
	endfunction

	function automatic logic [7:0] ignored_byte();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		while (is_letter(c) || is_sep(c))
			c = 8'($urandom_range(255));
		return c;
	endfunction

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(6))
			0: return CH_SPACE;
			1: return CH_NEWLINE;
			2: return CH_DOT;
			3: return CH_GT;
			4: return CH_LT;
			5: return CH_LBRACE;
			default: return CH_LPAREN;
		endcase
	endfunction

	// mostly switch and case, some keywords, extended keywords and plain tokens
	function automatic string pick_token();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return "switch";
		else if (pick < 50)
			return "case";
		else if (pick < 65)
			return kw_name[$urandom_range(31)];
		else if (pick < 75)
			return {kw_name[$urandom_range(31)], rand_letters(1, 4)};
		else if (pick < 92)
			return rand_letters(1, 12);
		return "";
	endfunction

	// token letters, sometimes with a capital first letter or a dropped byte inside
	task automatic put_word(input string w, input logic eot_last);
		logic       flip;
		logic [7:0] c;
		flip = ($urandom_range(9) == 0);
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (i == 0 && flip)
				c = c ^ 8'h20;
			if ($urandom_range(11) == 0)
				put(ignored_byte(), 1'b0);
			put(c, eot_last && i == w.len() - 1);
		end
	endtask

	task automatic add_random_text();
		string w;
		texts_made++;
		if ($urandom_range(9) == 0) begin
			// raw byte noise
			repeat ($urandom_range(15))
				put(8'($urandom_range(255)), 1'b0);
			put(8'($urandom_range(255)), 1'b1);
		end else begin
			repeat ($urandom_range(9, 1)) begin
				put_word(pick_token(), 1'b0);
				put(pick_sep(), 1'b0);
				if ($urandom_range(5) == 0)
					put(pick_sep(), 1'b0);
			end
			// last byte: a separator, a letter of an unfinished token, or a dropped byte
			case ($urandom_range(2))
				0: begin
					put_word(pick_token(), 1'b0);
					put(pick_sep(), 1'b1);
				end
				1: begin
					w = pick_token();
					if (w.len() == 0)
						w = "switch";
					put_word(w, 1'b1);
				end
				default: put(ignored_byte(), 1'b1);
			endcase
		end
	endtask

	// wait until every byte is taken and every report has come out
	task automatic drain();
		while (text_q.size() > 0 || in_valid || report_q.size() > 0) begin
			@(posedge clk);
			#1;
		end
		repeat (8) @(posedge clk);
		#1;
	endtask

	// driver: offers bytes and drives out_ready at the falling edge
	always @(negedge clk) begin
		text_byte_t nxt;
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (text_q.size() > 0 && !(gaps_on && $urandom_range(99) < 33)) begin
					nxt = text_q.pop_front();
					in_valid    <= 1'b1;
					char_code   <= nxt.ch;
					end_of_text <= nxt.eot;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !out_block && !(gaps_on && $urandom_range(99) < 33);
		end
	end

	// monitor: checks report words, predicts from accepted bytes, watchdog
	always @(posedge clk) begin
		rpt_t want;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					note_mismatch($sformatf("unexpected report kind %0d cases %0d",
						report_kind, case_count));
				end else begin
					want = report_q.pop_front();
					if (report_kind !== want.kind)
						note_mismatch($sformatf("report_kind %0d, expected %0d",
							report_kind, want.kind));
					if (case_count !== want.case_count)
						note_mismatch($sformatf("case_count %0d, expected %0d",
							case_count, want.case_count));
					if (keyword_total !== want.keyword_total)
						note_mismatch($sformatf("keyword_total %0d, expected %0d",
							keyword_total, want.keyword_total));
					if (switch_total !== want.switch_total)
						note_mismatch($sformatf("switch_total %0d, expected %0d",
							switch_total, want.switch_total));
					if (last_of_run !== want.last)
						note_mismatch($sformatf("last_of_run %0d, expected %0d",
							last_of_run, want.last));
					if (want.kind == KIND_TOTALS)
						n_total_rpt++;
					else
						n_switch_rpt++;
				end
			end
			if (in_valid && in_ready) begin
				count_byte(char_code, end_of_text);
				n_bytes++;
				if (end_of_text)
					n_texts++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("** c_keyword_switch_case_counter_core: FAILED **");
				$finish;
			end
		end
	end

	// long receiver hold-off while bytes keep coming
	initial begin
		while (!hold_req)
			@(posedge clk);
		out_block = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		out_block = 1'b0;
	end

	// stimulus sequence
	initial begin
		int rand_start;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// back-to-back switches, case count closed by end of text on a separator
		put_str("switch switch{case");
		put(CH_NEWLINE, 1'b1);
		// empty text with a top-bit byte
		put(8'hFF, 1'b1);
		// capitalized keyword, zero byte inside, unfinished last token
		put_str("Ca");
		put(8'h00, 1'b0);
		put_str("se.");
		put("x", 1'b1);
		drain();

		// random texts, no idling on either side
		rand_start = queued;
		while (queued - rand_start < 150)
			add_random_text();
		drain();

		// random texts with idling on both sides and one long output hold-off
		gaps_on  = 1'b1;
		hold_req = 1'b1;
		while (queued - rand_start < 470 || texts_made < 12)
			add_random_text();
		drain();

		$display("Run: %0d bytes in %0d texts, %0d switch reports and %0d totals checked,",
			n_bytes, n_texts, n_switch_rpt, n_total_rpt);
		$display("over directed corner texts, random texts, random stalls and a long hold-off.");
		if (err_cnt == 0)
			$display("** c_keyword_switch_case_counter_core: PASSED **");
		else
			$display("** c_keyword_switch_case_counter_core: FAILED **");
		$finish;
	end

endmodule
